// ===== hw/rtl/grh_pkg.sv =====
// grh_pkg: shared types, widths and the gamma code table for gamma_rgb_to_hsl
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package grh_pkg;

  localparam int CURVE_FRAC_BITS = 12;
  localparam int CODE_W = CURVE_FRAC_BITS;
  localparam int CURVE_MAX = (1 << CURVE_FRAC_BITS) - 1;
  localparam int NUM_W = CURVE_FRAC_BITS + 16;
  localparam int DEN_W = CURVE_FRAC_BITS + 1;
  localparam int POS_W = CURVE_FRAC_BITS + 3;
  localparam int QUO_W = 14;
  localparam int HUE_FULL = 5760;
  localparam int HUE_SCALE2 = 1920;
  localparam int SAT_SCALE2 = 25600;
  localparam int LIGHT_SCALE2 = 12800;

  // lightness divides by the fixed 2S, done as a multiply by a rounded-up reciprocal;
  // the shift leaves an error below 1/(2S) over the whole numerator range, so it is exact
  localparam int LIGHT_SHIFT = NUM_W + DEN_W;
  localparam longint LIGHT_RECIP = ((longint'(1) << LIGHT_SHIFT) + longint'(2 * CURVE_MAX) - 1)
                                   / longint'(2 * CURVE_MAX);
  localparam int PROD_W = 2 * NUM_W + 1;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [12:0] hue_out;
    logic [13:0] saturation_out;
    logic [13:0] lightness_out;
  } hsl_t;

  // rounded quotients are round(n / d) taken as floor((2n + d) / 2d)
  typedef struct packed {
    logic [NUM_W-1:0] h_num;
    logic [DEN_W-1:0] h_den;
    logic [NUM_W-1:0] s_num;
    logic [DEN_W-1:0] s_den;
    logic [NUM_W-1:0] l_num;
  } div_req_t;

  typedef logic [CODE_W-1:0] lut_t [256];

  function automatic lut_t build_lut();
    lut_t t;
    real x;
    real y;
    for (int i = 0; i < 256; i++) begin
      if (i == 0) begin
        t[i] = '0;
      end else begin
        x = real'(i) / 255.0;
        y = 1.055 * (x ** (1.0 / 2.4)) - 0.055;
        t[i] = CODE_W'($rtoi(y * real'(CURVE_MAX) + 0.5));
      end
    end
    return t;
  endfunction

  localparam lut_t GAMMA_LUT = build_lut();

endpackage
`default_nettype wire

// ===== hw/rtl/gamma_rgb_to_hsl.sv =====
// gamma_rgb_to_hsl: sRGB gamma-encoded RGB pixel to fixed-point HSL
// path from input accept to result valid: front register, two-word queue, divider stages, output register
// throughput one pixel per cycle while the output is taken; hue and saturation dividers are pipelined one bit per stage
// a two-word queue separates operand set-up from the divider pipeline
// synchronous active-low reset empties all stages; no memory clearing
// depends on grh_pkg, grh_front, grh_fifo, grh_back
`timescale 1ns / 1ps
`default_nettype none
module gamma_rgb_to_hsl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  grh_pkg::pix_t  in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output grh_pkg::hsl_t  out_data
);
  import grh_pkg::*;

  logic     f_valid, f_ready, q_valid, q_ready;
  div_req_t f_data, q_data;

  grh_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .req_valid(f_valid), .req_ready(f_ready), .req_data(f_data)
  );

  grh_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push_valid(f_valid), .push_ready(f_ready),
    .push_data(f_data), .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_data)
  );

  grh_back u_back (
    .clk(clk), .rst_n(rst_n), .req_valid(q_valid), .req_ready(q_ready),
    .req_data(q_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/grh_front.sv =====
// grh_front: gamma lookup, max/min and division operand set-up, one register stage
// depends on grh_pkg
`timescale 1ns / 1ps
`default_nettype none
module grh_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  grh_pkg::pix_t     in_data,
  output logic              req_valid,
  input  wire               req_ready,
  output grh_pkg::div_req_t req_data
);
  import grh_pkg::*;

  logic [CODE_W-1:0] r, g, b, hi, lo, spread, den_s;
  logic [DEN_W-1:0]  sum;
  logic [POS_W-1:0]  pos, sp_w;
  logic              red_max, green_max;
  div_req_t          req_nxt, req_r;
  logic              vld_r;

  always_comb begin
    r = GAMMA_LUT[in_data.red_in];
    g = GAMMA_LUT[in_data.green_in];
    b = GAMMA_LUT[in_data.blue_in];
    red_max = (r >= g) && (r >= b);
    green_max = !red_max && (g >= b);
    hi = red_max ? r : (green_max ? g : b);
    lo = (r <= g && r <= b) ? r : ((g <= b) ? g : b);
    spread = hi - lo;
    sum = DEN_W'(hi) + DEN_W'(lo);
    sp_w = POS_W'(spread);
    // hue position, one spread per sixth of the hue circle
    if (red_max) begin
      pos = (g >= b) ? POS_W'(g - b) : (POS_W'(6) * sp_w - POS_W'(b - g));
    end else if (green_max) begin
      pos = POS_W'(2) * sp_w + POS_W'(b) - POS_W'(r);
    end else begin
      pos = POS_W'(4) * sp_w + POS_W'(r) - POS_W'(g);
    end
    den_s = (sum <= DEN_W'(CURVE_MAX)) ? sum[CODE_W-1:0]
                                       : CODE_W'(DEN_W'(2 * CURVE_MAX) - sum);
    req_nxt.l_num = NUM_W'(LIGHT_SCALE2) * NUM_W'(sum) + NUM_W'(CURVE_MAX);
    if (spread == '0) begin
      // grey pixel: hue and saturation come out as zero
      req_nxt.h_num = '0;
      req_nxt.h_den = DEN_W'(1);
      req_nxt.s_num = '0;
      req_nxt.s_den = DEN_W'(1);
    end else begin
      req_nxt.h_num = NUM_W'(HUE_SCALE2) * NUM_W'(pos) + NUM_W'(spread);
      req_nxt.h_den = {spread, 1'b0};
      req_nxt.s_num = NUM_W'(SAT_SCALE2) * NUM_W'(spread) + NUM_W'(den_s);
      req_nxt.s_den = {den_s, 1'b0};
    end
  end

  assign in_ready = !vld_r || req_ready;
  assign req_valid = vld_r;
  assign req_data = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= req_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/grh_fifo.sv =====
// grh_fifo: two-word queue between front and back
// depends on grh_pkg
`timescale 1ns / 1ps
`default_nettype none
module grh_fifo (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push_valid,
  output logic              push_ready,
  input  grh_pkg::div_req_t push_data,
  output logic              pop_valid,
  input  wire               pop_ready,
  output grh_pkg::div_req_t pop_data
);
  import grh_pkg::*;

  div_req_t    mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/grh_div.sv =====
// grh_div: pipelined restoring divider, one quotient bit per stage
// depends on grh_pkg
`timescale 1ns / 1ps
`default_nettype none
module grh_div (
  input  wire                       clk,
  input  wire                       en,
  input  wire [grh_pkg::NUM_W-1:0]  num_i,
  input  wire [grh_pkg::DEN_W-1:0]  den_i,
  output logic [grh_pkg::QUO_W-1:0] quo_o
);
  import grh_pkg::*;

  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int BIT = QUO_W - 1 - s;
    logic [NUM_W-1:0] rem_in, trial;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign trial = NUM_W'(den_in) << BIT;
    assign ge = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? (rem_in - trial) : rem_in;
        den_r[s] <= den_in;
        quo_r[s] <= quo_in | (QUO_W'(ge) << BIT);
      end
    end
  end

  assign quo_o = quo_r[QUO_W-1];
endmodule
`default_nettype wire

// ===== hw/rtl/grh_back.sv =====
// grh_back: hue and saturation divider pipelines, lightness by reciprocal multiply,
// hue wrap and the output register; depends on grh_pkg, grh_div
`timescale 1ns / 1ps
`default_nettype none
module grh_back (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               req_valid,
  output logic              req_ready,
  input  grh_pkg::div_req_t req_data,
  output logic              out_valid,
  input  wire               out_ready,
  output grh_pkg::hsl_t     out_data
);
  import grh_pkg::*;

  logic [QUO_W-1:0]  vld_r;
  logic              adv;
  logic [QUO_W-1:0]  q_h, q_s, q_l, hue_w;
  logic [PROD_W-1:0] l_prod;
  logic [QUO_W-1:0]  l_dly_r [QUO_W];
  logic              out_vld_r;
  hsl_t              out_r;

  // whole pipe stalls together when the output word is not taken
  assign adv = !out_vld_r || out_ready;
  assign req_ready = adv;

  grh_div u_div_h (.clk(clk), .en(adv), .num_i(req_data.h_num), .den_i(req_data.h_den),
                   .quo_o(q_h));
  grh_div u_div_s (.clk(clk), .en(adv), .num_i(req_data.s_num), .den_i(req_data.s_den),
                   .quo_o(q_s));

  // lightness quotient in one step, then delayed to line up with the dividers
  assign l_prod = PROD_W'(req_data.l_num) * PROD_W'(LIGHT_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      l_dly_r[0] <= l_prod[LIGHT_SHIFT +: QUO_W];
      for (int s = 1; s < QUO_W; s++) begin
        l_dly_r[s] <= l_dly_r[s-1];
      end
    end
  end

  assign q_l = l_dly_r[QUO_W-1];

  assign hue_w = (q_h >= QUO_W'(HUE_FULL)) ? (q_h - QUO_W'(HUE_FULL)) : q_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[QUO_W-2:0], req_valid};
      out_vld_r <= vld_r[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.hue_out <= hue_w[12:0];
      out_r.saturation_out <= q_s;
      out_r.lightness_out <= q_l;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data = out_r;
endmodule
`default_nettype wire

// ===== bench/gamma_rgb_to_hsl_check.sv =====
// gamma_rgb_to_hsl_check: watches both channels of gamma_rgb_to_hsl, predicts each
// hsl word from its pixel word and compares field by field; depends on grh_pkg
`timescale 1ns / 1ps
module gamma_rgb_to_hsl_check (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  input  wire            in_ready,
  input  grh_pkg::pix_t  in_data,
  input  wire            out_valid,
  input  wire            out_ready,
  input  grh_pkg::hsl_t  out_data,
  output int             fail_count,
  output int             pending_count
);
  import grh_pkg::*;

  localparam longint SCALE = 4095;

  logic [11:0]   srgb_code [256];
  hsl_t          hsl_expected [$];

  // exact table: code is the smallest e with f(i/255) < (e+0.5)/S,
  // compared as 12th powers so no rounding creeps in
  function automatic logic [11:0] encode_code(int unsigned i);
    bit [447:0] lhs;
    bit [447:0] rhs;
    int unsigned lo_e;
    int unsigned hi_e;
    int unsigned mid;
    longint unsigned num;
    longint unsigned den;
    den = 2110 * SCALE;
    lhs = 1;
    for (int k = 0; k < 5; k++) lhs = lhs * i;
    for (int k = 0; k < 12; k++) lhs = lhs * den;
    lo_e = 0;
    hi_e = SCALE;
    while (lo_e < hi_e) begin
      mid = (lo_e + hi_e) >> 1;
      num = 2000 * mid + 1000 + 110 * SCALE;
      rhs = 1;
      for (int k = 0; k < 12; k++) rhs = rhs * num;
      for (int k = 0; k < 5; k++) rhs = rhs * 255;
      if (lhs < rhs) hi_e = mid;
      else lo_e = mid + 1;
    end
    return lo_e[11:0];
  endfunction

  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic hsl_t predict_hsl(pix_t p);
    longint unsigned r, g, b, hi_c, lo_c, spread, sum, den, pos;
    longint unsigned hue, sat, light;
    hsl_t h;
    r = srgb_code[p.red_in];
    g = srgb_code[p.green_in];
    b = srgb_code[p.blue_in];
    hi_c = r;
    if (g > hi_c) hi_c = g;
    if (b > hi_c) hi_c = b;
    lo_c = r;
    if (g < lo_c) lo_c = g;
    if (b < lo_c) lo_c = b;
    spread = hi_c - lo_c;
    sum = hi_c + lo_c;
    light = round_div(sum * 6400, SCALE);
    hue = 0;
    sat = 0;
    if (spread != 0) begin
      den = (sum <= SCALE) ? sum : (2 * SCALE - sum);
      sat = round_div(spread * 12800, den);
      // red wins ties over green, green over blue
      if (hi_c == r) pos = (g >= b) ? g - b : 6 * spread - (b - g);
      else if (hi_c == g) pos = 2 * spread + b - r;
      else pos = 4 * spread + r - g;
      hue = round_div(pos * 960, spread);
      if (hue >= 5760) hue -= 5760;
    end
    h.hue_out = hue[12:0];
    h.saturation_out = sat[13:0];
    h.lightness_out = light[13:0];
    return h;
  endfunction

  initial begin
    fail_count = 0;
    for (int i = 0; i < 256; i++) srgb_code[i] = encode_code(i);
  end

  assign pending_count = hsl_expected.size();

  always @(posedge clk) begin
    hsl_t want;
    int errs;
    errs = 0;
    if (rst_n) begin
      if (in_valid && in_ready) hsl_expected.push_back(predict_hsl(in_data));
      if (out_valid && out_ready) begin
        if (hsl_expected.size() == 0) begin
          $error("hsl word with none expected: %h", out_data);
          errs++;
        end else begin
          want = hsl_expected.pop_front();
          if (out_data.hue_out !== want.hue_out) begin
            $error("hue_out expected %0d actual %0d", want.hue_out, out_data.hue_out);
            errs++;
          end
          if (out_data.saturation_out !== want.saturation_out) begin
            $error("saturation_out expected %0d actual %0d",
                   want.saturation_out, out_data.saturation_out);
            errs++;
          end
          if (out_data.lightness_out !== want.lightness_out) begin
            $error("lightness_out expected %0d actual %0d",
                   want.lightness_out, out_data.lightness_out);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== bench/gamma_rgb_to_hsl_test.sv =====
// gamma_rgb_to_hsl_test: drives pixel words into gamma_rgb_to_hsl with random
// gaps and output stalls; depends on grh_pkg, gamma_rgb_to_hsl, gamma_rgb_to_hsl_check
`timescale 1ns / 1ps
module gamma_rgb_to_hsl_test;
  import grh_pkg::*;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  pix_t  in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  hsl_t  out_data;
  int    fail_count;
  int    pending_count;

  int    sender_gap_max = 10;
  int    stall_max = 10;
  int    stall_left = 0;
  int    words_out = 0;
  bit    long_hold_done = 1'b0;

  always #10 clk = ~clk;

  gamma_rgb_to_hsl u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  gamma_rgb_to_hsl_check u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // receiver: random stall per word, plus one long hold to back the block up
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        words_out <= words_out + 1;
        if (words_out == 500 && !long_hold_done) begin
          long_hold_done <= 1'b1;
          stall_left <= 300;
          out_ready <= 1'b0;
        end else begin
          stall_left <= $urandom_range(0, stall_max);
          if (stall_max != 0 && $urandom_range(0, 1)) out_ready <= 1'b0;
        end
      end else if (!out_ready) begin
        if (stall_left > 0) stall_left <= stall_left - 1;
        else out_ready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{red_in: r, green_in: g, blue_in: b};
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [7:0] pick_byte(int mode);
    case (mode)
      0: return 8'($urandom_range(0, 255));
      1: return ($urandom_range(0, 1)) ? 8'd255 : 8'd0;
      default: return 8'($urandom_range(0, 3)) + (($urandom_range(0, 1)) ? 8'd252 : 8'd0);
    endcase
  endfunction

  initial begin
    logic [7:0] base;
    logic [7:0] r, g, b;
    int mode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, primaries, ties, greys and the hue wrap near red
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd200, 8'd10);
    send_pixel(8'd10, 8'd200, 8'd200);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd250, 8'd240, 8'd245);
    send_pixel(8'd170, 8'd85, 8'd85);
    send_pixel(8'd255, 8'd128, 8'd0);

    for (int n = 0; n < 1600; n++) begin
      // alternate stretches of busy and idle traffic
      if (n % 200 == 0) begin
        sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
        stall_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
      end
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        r = pick_byte(0); g = pick_byte(0); b = pick_byte(0);
      end else if (mode < 8) begin
        // near-grey: small spread
        base = 8'($urandom_range(0, 255));
        r = base;
        g = base ^ 8'($urandom_range(0, 3));
        b = base ^ 8'($urandom_range(0, 3));
      end else begin
        r = pick_byte(mode - 7); g = pick_byte($urandom_range(0, 2));
        b = pick_byte($urandom_range(0, 2));
      end
      send_pixel(r, g, b);
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/grh_pkg.sv
hw/rtl/grh_front.sv
hw/rtl/grh_fifo.sv
hw/rtl/grh_div.sv
hw/rtl/grh_back.sv
hw/rtl/gamma_rgb_to_hsl.sv
bench/gamma_rgb_to_hsl_check.sv
bench/gamma_rgb_to_hsl_test.sv
